### sv/assert_macros.svh
// Assertion macros shared by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is low.
`define UCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define UCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define UCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/ucc_pkg.sv
// Package with the types, constants and helpers of the UDP checksum checker.
package ucc_pkg;

    // Queue between the classifier and the accumulator.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] CNT_MAX   = 16'hFFFF;
    localparam logic [16:0] HDR_BYTES = 17'd8;

    // Header byte positions.
    localparam logic [2:0] HB_SRC_HI  = 3'd0;
    localparam logic [2:0] HB_SRC_LO  = 3'd1;
    localparam logic [2:0] HB_DST_HI  = 3'd2;
    localparam logic [2:0] HB_DST_LO  = 3'd3;
    localparam logic [2:0] HB_LEN_HI  = 3'd4;
    localparam logic [2:0] HB_LEN_LO  = 3'd5;
    localparam logic [2:0] HB_CSUM_HI = 3'd6;
    localparam logic [2:0] HB_CSUM_LO = 3'd7;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_SUM = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;
    localparam logic [1:0] ST_BAD_LEN = 2'd3;

    // One classified byte, as handed from the front to the back.
    typedef struct packed {
        logic        start;
        logic [16:0] pseudo;
        logic        add_en;
        logic [15:0] word;
        logic        hdr_en;
        logic [2:0]  hdr_idx;
        logic [7:0]  data_byte;
        logic        last;
        logic [16:0] total;
    } t_op;

    typedef struct packed {
        logic [Q_CW-1:0] count;
        logic            full;
        logic            empty;
    } t_q_stat;

    typedef struct packed {
        logic fin_valid;
        logic out_valid;
    } t_back_stat;

    // One end-around carry fold of a short sum.
    function automatic logic [16:0] ucc_fold(input logic [18:0] x);
        ucc_fold = {1'b0, x[15:0]} + {14'd0, x[18:16]};
    endfunction

endpackage

### sv/ucc_if.sv
// Valid/ready channel interfaces for the checker's input and result items.
interface ucc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;

    modport source (output valid, data_byte, first, last, src_addr, dst_addr, protocol,
                    input ready);
    modport sink (input valid, data_byte, first, last, src_addr, dst_addr, protocol,
                  output ready);
endinterface

interface ucc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] computed_checksum;
    logic [15:0] received_checksum;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] length_field;
    logic [1:0]  status;

    modport source (output valid, computed_checksum, received_checksum, source_port,
                    dest_port, length_field, status, input ready);
    modport sink (input valid, computed_checksum, received_checksum, source_port,
                  dest_port, length_field, status, output ready);
endinterface

### sv/ucc_front.sv
// Byte classifier: tracks the byte position, pairs bytes into words.
module ucc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ucc_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output ucc_pkg::t_op    o_op
);

    logic [15:0] r_cnt, n_cnt;
    logic [7:0]  r_held, n_held;
    logic        start;
    logic [15:0] idx;
    logic        even;
    logic        accept;
    logic [18:0] pseudo_raw;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign o_push     = accept;

    always_comb begin
        start = i_in.first || (r_cnt == 16'd0);
        idx   = start ? 16'd0 : r_cnt;
        even  = !idx[0];
        pseudo_raw = 19'(i_in.src_addr[31:16]) + 19'(i_in.src_addr[15:0])
                   + 19'(i_in.dst_addr[31:16]) + 19'(i_in.dst_addr[15:0])
                   + 19'(i_in.protocol);

        o_op.start     = start;
        o_op.pseudo    = ucc_pkg::ucc_fold(pseudo_raw);
        // An odd last byte is padded; the checksum field itself is skipped.
        o_op.add_en    = even ? (i_in.last && (idx != 16'(ucc_pkg::HB_CSUM_HI)))
                              : (idx != 16'(ucc_pkg::HB_CSUM_LO));
        o_op.word      = even ? {i_in.data_byte, 8'h00} : {r_held, i_in.data_byte};
        o_op.hdr_en    = (idx < 16'(ucc_pkg::HDR_BYTES));
        o_op.hdr_idx   = idx[2:0];
        o_op.data_byte = i_in.data_byte;
        o_op.last      = i_in.last;
        o_op.total     = {1'b0, idx} + 17'd1;

        n_cnt  = r_cnt;
        n_held = r_held;
        if (accept) begin
            if (even) begin
                n_held = i_in.data_byte;
            end
            if (i_in.last) begin
                n_cnt = 16'd0;
            end else if (idx != ucc_pkg::CNT_MAX) begin
                n_cnt = idx + 16'd1;
            end else begin
                n_cnt = idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 16'd0;
            r_held <= 8'd0;
        end else begin
            r_cnt  <= n_cnt;
            r_held <= n_held;
        end
    end

endmodule

### sv/ucc_fifo.sv
// Short queue of classified bytes between the front and the back.
module ucc_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ucc_pkg::t_op       i_op,
    input  logic               i_pop,
    output ucc_pkg::t_op       o_op,
    output ucc_pkg::t_q_stat   o_stat
);

    ucc_pkg::t_op                r_mem [ucc_pkg::Q_DEPTH];
    logic [ucc_pkg::Q_AW-1:0]    r_wr, n_wr;
    logic [ucc_pkg::Q_AW-1:0]    r_rd, n_rd;
    logic [ucc_pkg::Q_CW-1:0]    r_count, n_count;
    logic                        do_push, do_pop;

    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == ucc_pkg::Q_CW'(ucc_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_op         = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == ucc_pkg::Q_AW'(ucc_pkg::Q_DEPTH - 1)) ? '0
                 : r_wr + ucc_pkg::Q_AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == ucc_pkg::Q_AW'(ucc_pkg::Q_DEPTH - 1)) ? '0
                 : r_rd + ucc_pkg::Q_AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + ucc_pkg::Q_CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - ucc_pkg::Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

### sv/ucc_back.sv
// Accumulator, header capture, final check and output register.
module ucc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data,
    input  logic                 i_valid,
    input  ucc_pkg::t_op         i_op,
    output logic                 o_pop,
    output ucc_pkg::t_back_stat  o_stat,
    ucc_out_if.source            o_out
);

    logic        r_accept_zero;
    logic [16:0] r_sum, n_sum, base_sum;
    logic [15:0] r_src, n_src, r_dst, n_dst, r_len, n_len, r_rx, n_rx;

    // Datagram waiting for its final check.
    logic        r_fin_valid;
    logic [16:0] r_fin_sum;
    logic [15:0] r_fin_src, r_fin_dst, r_fin_len, r_fin_rx;
    logic [16:0] r_fin_total;
    logic        fin_move;

    logic        r_out_valid;
    logic [15:0] r_out_cs, r_out_rx, r_out_src, r_out_dst, r_out_len;
    logic [1:0]  r_out_status;

    logic [16:0] fold1, fold2;
    logic [15:0] cs;
    logic [1:0]  status;

    assign fin_move = r_fin_valid && (!r_out_valid || o_out.ready);
    assign o_pop    = i_valid && (!i_op.last || !r_fin_valid || fin_move);

    assign o_stat.fin_valid = r_fin_valid;
    assign o_stat.out_valid = r_out_valid;

    always_comb begin
        base_sum = i_op.start ? i_op.pseudo : r_sum;
        n_sum    = i_op.add_en ? ucc_pkg::ucc_fold(19'(base_sum) + 19'(i_op.word))
                               : base_sum;
        n_src = i_op.start ? 16'd0 : r_src;
        n_dst = i_op.start ? 16'd0 : r_dst;
        n_len = i_op.start ? 16'd0 : r_len;
        n_rx  = i_op.start ? 16'd0 : r_rx;
        if (i_op.hdr_en) begin
            unique case (i_op.hdr_idx)
                ucc_pkg::HB_SRC_HI:  n_src[15:8] = i_op.data_byte;
                ucc_pkg::HB_SRC_LO:  n_src[7:0]  = i_op.data_byte;
                ucc_pkg::HB_DST_HI:  n_dst[15:8] = i_op.data_byte;
                ucc_pkg::HB_DST_LO:  n_dst[7:0]  = i_op.data_byte;
                ucc_pkg::HB_LEN_HI:  n_len[15:8] = i_op.data_byte;
                ucc_pkg::HB_LEN_LO:  n_len[7:0]  = i_op.data_byte;
                ucc_pkg::HB_CSUM_HI: n_rx[15:8]  = i_op.data_byte;
                ucc_pkg::HB_CSUM_LO: n_rx[7:0]   = i_op.data_byte;
            endcase
        end
    end

    // Final check: the second copy of the length goes into the sum here.
    always_comb begin
        fold1 = ucc_pkg::ucc_fold(19'(r_fin_sum) + 19'(r_fin_len));
        fold2 = ucc_pkg::ucc_fold(19'(fold1));
        cs    = ~fold2[15:0];
        if (cs == 16'd0) begin
            cs = 16'hFFFF;
        end
        priority if (r_fin_total < ucc_pkg::HDR_BYTES) begin
            status = ucc_pkg::ST_SHORT;
        end else if ({1'b0, r_fin_len} != r_fin_total) begin
            status = ucc_pkg::ST_BAD_LEN;
        end else if (r_fin_rx == 16'd0 && r_accept_zero) begin
            status = ucc_pkg::ST_OK;
        end else if (r_fin_rx != cs) begin
            status = ucc_pkg::ST_BAD_SUM;
        end else begin
            status = ucc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_zero <= 1'b1;
            r_fin_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_accept_zero <= i_cfg_data;
            end
            if (o_pop && i_op.last) begin
                r_fin_valid <= 1'b1;
            end else if (fin_move) begin
                r_fin_valid <= 1'b0;
            end
            if (fin_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 17'd0;
            r_src <= 16'd0;
            r_dst <= 16'd0;
            r_len <= 16'd0;
            r_rx  <= 16'd0;
        end else if (o_pop) begin
            r_sum <= n_sum;
            r_src <= n_src;
            r_dst <= n_dst;
            r_len <= n_len;
            r_rx  <= n_rx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_op.last) begin
            r_fin_sum   <= n_sum;
            r_fin_src   <= n_src;
            r_fin_dst   <= n_dst;
            r_fin_len   <= n_len;
            r_fin_rx    <= n_rx;
            r_fin_total <= i_op.total;
        end
        if (fin_move) begin
            r_out_cs     <= cs;
            r_out_rx     <= r_fin_rx;
            r_out_src    <= r_fin_src;
            r_out_dst    <= r_fin_dst;
            r_out_len    <= r_fin_len;
            r_out_status <= status;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.computed_checksum = r_out_cs;
    assign o_out.received_checksum = r_out_rx;
    assign o_out.source_port       = r_out_src;
    assign o_out.dest_port         = r_out_dst;
    assign o_out.length_field      = r_out_len;
    assign o_out.status            = r_out_status;

endmodule

### sv/udp_checksum_checker.sv
// Top level of the UDP over IPv4 checksum checker.
//
//  Channel  Direction  Handshake      Carries
//  i_in     in         valid/ready    one datagram byte, flags, pseudo-header fields
//  o_out    out        valid/ready    checksums, ports, length and status per datagram
//  i_cfg    in         write enable   accept_zero bit
//
// One byte is taken per cycle while the queue has room; the rate is set by the
// single fold adder in the accumulator, which adds at most one word per cycle.
// A result follows the last byte through the queue and the final-check slot.
// Reset is synchronous and active low; accept_zero comes out of reset set.
// A stalled output fills the final-check slot and then the four-entry queue;
// only then is input ready dropped.
`include "assert_macros.svh"

module udp_checksum_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ucc_in_if.sink     i_in,
    ucc_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);

    // Classified bytes travel from the front through the queue to the back.
    logic                 push;
    logic                 pop;
    ucc_pkg::t_op         front_op;
    ucc_pkg::t_op         head_op;
    ucc_pkg::t_q_stat     q_stat;
    ucc_pkg::t_back_stat  b_stat;

    // The front pairs bytes into big-endian words and tracks the byte position.
    ucc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_stat.full),
        .o_push  (push),
        .o_op    (front_op)
    );

    ucc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_stat  (q_stat)
    );

    // The back keeps the running sum, captures the header and checks the result.
    ucc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (!q_stat.empty),
        .i_op       (head_op),
        .o_pop      (pop),
        .o_stat     (b_stat),
        .o_out      (o_out)
    );

    // The queue count never passes its depth.
    `UCC_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, 1'b1, q_stat.count <= ucc_pkg::Q_CW'(ucc_pkg::Q_DEPTH), "queue count beyond depth")
    // A result can only appear from a datagram waiting in the final-check slot.
    `UCC_ASSERT_NXT(a_no_phantom, i_clk, i_rst_n, !b_stat.fin_valid && !o_out.valid, !o_out.valid, "result without a finished datagram")
    // Input is held off only while the queue is full.
    `UCC_ASSERT_IMP(a_ready_full, i_clk, i_rst_n, !i_in.ready, q_stat.full && q_stat.count != '0, "input stalled with room in the queue")

endmodule

### bench/udp_checksum_checker_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the UDP checksum checker: directed and random datagrams against a built-in model.
module udp_checksum_checker_test;

    // No handshake on either channel for this many cycles means the block is stuck.
    localparam int STALL_LIMIT = 1000;
    // Length of the deliberate result back-pressure that fills the block up.
    localparam int LONG_HOLD   = 80;
    // Cycles allowed after the last result before the block counts as idle.
    localparam int SETTLE      = 10;

    // One byte on the input channel with the fields that ride along with it.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first;
        logic        last;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol;
    } t_byte_item;

    // The report the block gives for one datagram.
    typedef struct packed {
        logic [15:0] computed_checksum;
        logic [15:0] received_checksum;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] length_field;
        logic [1:0]  status;
    } t_dg_report;

    // Flavors of generated datagram. DG_CUT never marks a byte as last.
    typedef enum int {
        DG_GOOD,
        DG_ZERO_SUM,
        DG_BAD_SUM,
        DG_BAD_LEN,
        DG_ALL_ONES,
        DG_CUT
    } t_dg_kind;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic cfg_we   = 1'b0;
    logic cfg_data = 1'b0;

    ucc_in_if  in_if();
    ucc_out_if out_if();

    udp_checksum_checker uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bytes waiting to be offered, and reports the block still owes us.
    t_byte_item wire_bytes [$];
    t_dg_report expected_reports [$];

    int queued_items   = 0;
    int accepted_items = 0;
    int failures       = 0;
    int quiet_cycles   = 0;

    // Idle controls. The main sequence flips these between phases.
    bit src_idle_on  = 1'b0;
    bit sink_idle_on = 1'b0;
    int hold_asked   = 0;
    int hold_served  = 0;
    int hold_left    = 0;
    int send_gap     = 0;
    int sink_gap     = 0;

    t_byte_item on_wire;
    t_dg_report report_new;
    t_dg_report report_due;

    // Model state. It mirrors what the block keeps between bytes of a datagram.
    logic        zero_ok    = 1'b1;
    logic [31:0] sum_acc    = '0;
    logic [7:0]  held_hi    = '0;
    logic [15:0] rx_count   = '0;
    logic [15:0] src_port_q = '0;
    logic [15:0] dst_port_q = '0;
    logic [15:0] len_q      = '0;
    logic [15:0] csum_q     = '0;

    // One end-around carry fold.
    function automatic logic [31:0] end_around(input logic [31:0] x);
        return {16'h0, x[15:0]} + {16'h0, x[31:16]};
    endfunction

    // Advances the datagram model by one accepted byte. Returns 1 when the
    // byte closes a datagram, with the report the block must then produce.
    function automatic bit checksum_step(input t_byte_item b, output t_dg_report r);
        logic [15:0] idx;
        logic [16:0] total;
        logic [31:0] s;
        logic [15:0] cs;
        r = '0;
        // A byte marked first, or any byte after a closed datagram, opens a
        // new one. The pseudo-header goes in right away, except the length,
        // which is only known at the end.
        if (b.first || rx_count == 16'h0) begin
            sum_acc    = '0;
            sum_acc    = end_around(sum_acc + b.src_addr[31:16]);
            sum_acc    = end_around(sum_acc + b.src_addr[15:0]);
            sum_acc    = end_around(sum_acc + b.dst_addr[31:16]);
            sum_acc    = end_around(sum_acc + b.dst_addr[15:0]);
            sum_acc    = end_around(sum_acc + b.protocol);
            held_hi    = '0;
            rx_count   = '0;
            src_port_q = '0;
            dst_port_q = '0;
            len_q      = '0;
            csum_q     = '0;
        end
        idx = rx_count;
        case (idx)
            ucc_pkg::HB_SRC_HI:  src_port_q[15:8] = b.data_byte;
            ucc_pkg::HB_SRC_LO:  src_port_q[7:0]  = b.data_byte;
            ucc_pkg::HB_DST_HI:  dst_port_q[15:8] = b.data_byte;
            ucc_pkg::HB_DST_LO:  dst_port_q[7:0]  = b.data_byte;
            ucc_pkg::HB_LEN_HI:  len_q[15:8]      = b.data_byte;
            ucc_pkg::HB_LEN_LO:  len_q[7:0]       = b.data_byte;
            ucc_pkg::HB_CSUM_HI: csum_q[15:8]     = b.data_byte;
            ucc_pkg::HB_CSUM_LO: csum_q[7:0]      = b.data_byte;
            default: ;
        endcase
        // Bytes pair up big-endian. The checksum field stays out of the sum,
        // and an odd last byte goes in padded with a zero low byte.
        if (!idx[0]) begin
            held_hi = b.data_byte;
            if (b.last && idx != ucc_pkg::HB_CSUM_HI)
                sum_acc = end_around(sum_acc + {b.data_byte, 8'h00});
        end else if (idx != ucc_pkg::HB_CSUM_LO) begin
            sum_acc = end_around(sum_acc + {held_hi, b.data_byte});
        end
        // The count sticks at its top value on overlong datagrams.
        if (rx_count != 16'hFFFF)
            rx_count = rx_count + 16'd1;
        if (!b.last)
            return 1'b0;

        total = {1'b0, idx} + 17'd1;
        s = end_around(end_around(sum_acc + len_q));
        cs = ~s[15:0];
        if (cs == 16'h0)
            cs = 16'hFFFF;
        // Short beats bad length, which beats a checksum mismatch.
        if (total < ucc_pkg::HDR_BYTES)
            r.status = ucc_pkg::ST_SHORT;
        else if ({1'b0, len_q} != total)
            r.status = ucc_pkg::ST_BAD_LEN;
        else if (csum_q == 16'h0 && zero_ok)
            r.status = ucc_pkg::ST_OK;
        else if (csum_q != cs)
            r.status = ucc_pkg::ST_BAD_SUM;
        else
            r.status = ucc_pkg::ST_OK;
        r.computed_checksum = cs;
        r.received_checksum = csum_q;
        r.source_port       = src_port_q;
        r.dest_port         = dst_port_q;
        r.length_field      = len_q;
        rx_count = '0;
        sum_acc  = '0;
        held_hi  = '0;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (seen !== want) begin
            $error("%s: expected %h, got %h", name, want, seen);
            failures++;
        end
    endtask

    // Builds one datagram of n bytes with random content and queues it. For
    // datagrams of at least a full header, other than DG_CUT, the length and
    // checksum fields follow the kind; shorter and cut ones stay pure noise.
    task automatic queue_datagram(input int n, input t_dg_kind kind, input bit mark_first,
                                  input logic [31:0] src, input logic [31:0] dst,
                                  input logic [7:0] proto);
        logic [7:0]  dg [$];
        logic [15:0] len_word;
        logic [15:0] cs;
        logic [31:0] s;
        t_byte_item  b;
        int          k;
        for (k = 0; k < n; k++)
            dg.push_back(8'($urandom));
        if (n >= 8 && kind != DG_CUT) begin
            len_word = 16'(n);
            if (kind == DG_BAD_LEN) begin
                len_word = 16'($urandom);
                if (len_word == 16'(n))
                    len_word = len_word + 16'd1;
            end
            dg[4] = len_word[15:8];
            dg[5] = len_word[7:0];
            dg[6] = 8'h00;
            dg[7] = 8'h00;
            if (kind == DG_ALL_ONES) begin
                dg[n - 2] = 8'h00;
                dg[n - 1] = 8'h00;
            end
            s = src[31:16] + src[15:0] + dst[31:16] + dst[15:0] + proto + len_word;
            for (k = 0; k < n; k += 2)
                s = s + {dg[k], (k + 1 < n) ? dg[k + 1] : 8'h00};
            s = end_around(end_around(end_around(s)));
            // Tune the last word so the sum comes to all ones, which makes the
            // complemented checksum zero and forces the 0xFFFF substitution.
            if (kind == DG_ALL_ONES) begin
                cs = 16'hFFFF - s[15:0];
                dg[n - 2] = cs[15:8];
                dg[n - 1] = cs[7:0];
                s = 32'h0000_FFFF;
            end
            cs = ~s[15:0];
            if (cs == 16'h0)
                cs = 16'hFFFF;
            case (kind)
                DG_ZERO_SUM: cs = 16'h0;
                DG_BAD_SUM:  cs = cs ^ 16'($urandom_range(1, 16'hFFFF));
                default: ;
            endcase
            dg[6] = cs[15:8];
            dg[7] = cs[7:0];
        end
        for (k = 0; k < n; k++) begin
            b.data_byte = dg[k];
            b.first     = (k == 0) && mark_first;
            b.last      = (k == n - 1) && (kind != DG_CUT);
            // The address fields only count on the opening byte; elsewhere
            // they carry noise that the block has to ignore.
            if (k == 0) begin
                b.src_addr = src;
                b.dst_addr = dst;
                b.protocol = proto;
            end else begin
                b.src_addr = $urandom;
                b.dst_addr = $urandom;
                b.protocol = 8'($urandom);
            end
            wire_bytes.push_back(b);
        end
        queued_items += n;
    endtask

    // Mostly well-formed datagrams of modest size, mixed with the error
    // flavors, short ones and datagrams abandoned midway and restarted.
    task automatic queue_random_traffic(input int n_items);
        int         stop_at;
        int         r;
        int         n;
        logic [7:0] proto;
        t_dg_kind   kind;
        stop_at = queued_items + n_items;
        while (queued_items < stop_at) begin
            r     = $urandom_range(0, 99);
            n     = $urandom_range(8, 32);
            proto = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd17;
            if (r < 10) begin
                queue_datagram($urandom_range(1, 12), DG_CUT, 1'($urandom_range(0, 1)),
                               $urandom, $urandom, proto);
                queue_datagram(n, DG_GOOD, 1'b1, $urandom, $urandom, proto);
            end else begin
                if (r < 55) begin
                    kind = DG_GOOD;
                end else if (r < 63) begin
                    kind = DG_ZERO_SUM;
                end else if (r < 71) begin
                    kind = DG_BAD_SUM;
                end else if (r < 79) begin
                    kind = DG_BAD_LEN;
                end else if (r < 86) begin
                    kind = DG_ALL_ONES;
                    n = 2 * $urandom_range(5, 16);
                end else begin
                    kind = DG_GOOD;
                    n = $urandom_range(1, 7);
                end
                // About one datagram in four relies on the implicit start.
                queue_datagram(n, kind, $urandom_range(0, 3) != 0, $urandom, $urandom, proto);
            end
        end
    endtask

    // Waits until every queued byte is taken and every report is back, then
    // lets the pipeline settle so a register write finds the block idle.
    task automatic drain();
        do
            @(posedge clk);
        while (accepted_items != queued_items || expected_reports.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_accept_zero(input logic v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        zero_ok   = v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Input driver. On each accepted byte the model is stepped and any report
    // it predicts joins the queue of reports due.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                accepted_items++;
                if (checksum_step(on_wire, report_new))
                    expected_reports.push_back(report_new);
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (wire_bytes.size() == 0) begin
                    in_if.valid <= 1'b0;
                end else if (src_idle_on && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(0, 9);
                    in_if.valid <= 1'b0;
                end else begin
                    on_wire = wire_bytes.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.data_byte <= on_wire.data_byte;
                    in_if.first     <= on_wire.first;
                    in_if.last      <= on_wire.last;
                    in_if.src_addr  <= on_wire.src_addr;
                    in_if.dst_addr  <= on_wire.dst_addr;
                    in_if.protocol  <= on_wire.protocol;
                end
            end
        end
    end

    // Result ready. A requested long hold takes priority over the short
    // random bursts and is counted out here.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = LONG_HOLD - 1;
            out_if.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            out_if.ready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
            sink_gap = $urandom_range(0, 9);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Result checker. Reports come back in datagram order.
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (expected_reports.size() == 0) begin
                $error("report with no datagram outstanding: computed_checksum %h, status %0d",
                       out_if.computed_checksum, out_if.status);
                failures++;
            end else begin
                report_due = expected_reports.pop_front();
                check_field("computed_checksum", report_due.computed_checksum,
                            out_if.computed_checksum);
                check_field("received_checksum", report_due.received_checksum,
                            out_if.received_checksum);
                check_field("source_port", report_due.source_port, out_if.source_port);
                check_field("dest_port", report_due.dest_port, out_if.dest_port);
                check_field("length_field", report_due.length_field, out_if.length_field);
                check_field("status", 16'(report_due.status), 16'(out_if.status));
            end
        end
    end

    // Watchdog on handshakes of either channel.
    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        in_if.first     = 1'b0;
        in_if.last      = 1'b0;
        in_if.src_addr  = '0;
        in_if.dst_addr  = '0;
        in_if.protocol  = '0;
        out_if.ready    = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_accept_zero(1'b1);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;

        // Directed datagrams. A single byte that is both first and last, with
        // all address and protocol bits low. Then a seven-byte datagram that
        // opens without the first flag, ends on the checksum high byte, and
        // has every address and protocol bit high. Then one whose sum is all
        // ones, and a header-only datagram with no checksum sent.
        queue_datagram(1, DG_GOOD, 1'b1, 32'h0000_0000, 32'h0000_0000, 8'h00);
        queue_datagram(7, DG_GOOD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        queue_datagram(10, DG_ALL_ONES, 1'b1, $urandom, $urandom, 8'd17);
        queue_datagram(8, DG_ZERO_SUM, 1'b1, $urandom, $urandom, 8'd17);
        queue_random_traffic(280);
        drain();

        // A received zero checksum now has to match like any other value.
        write_accept_zero(1'b0);
        queue_random_traffic(180);
        drain();

        // The sender runs flat out while the result side holds off long
        // enough for the block to back up and drop input ready.
        write_accept_zero(1'b1);
        src_idle_on = 1'b0;
        queue_random_traffic(230);
        @(posedge clk);
        hold_asked <= hold_asked + 1;
        drain();

        // A short stretch with zero checksums checked again.
        write_accept_zero(1'b0);
        src_idle_on = 1'b1;
        queue_random_traffic(80);
        drain();

        // Closing stretch at full rate on both sides.
        write_accept_zero(1'b1);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        queue_random_traffic(230);
        drain();

        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/ucc_pkg.sv
sv/ucc_if.sv
sv/ucc_front.sv
sv/ucc_fifo.sv
sv/ucc_back.sv
sv/udp_checksum_checker.sv
bench/udp_checksum_checker_test.sv
